### hw/rtl/ffua_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffua_pkg
// Shared constants and types of the first-fit unit allocator: map word
// geometry, arithmetic widths, request modes, sequencer states and the row evaluation record.
// ----------------------------------------------------------------------------
package ffua_pkg;

   // occupancy map is held as words of WORD_W units
   localparam int WORD_W     = 16;
   localparam int WORD_SHIFT = 4;
   localparam int POS_W      = 4;
   // highest used position plus one, 0 when the word prefix is free
   localparam int PP_W       = 5;
   // wide enough for offset + length sums and for run counts of pools below 2**18 units
   localparam int CALC_W     = 18;

   localparam int LENGTH_W   = 11;
   localparam int OFFSET_W   = 10;

   localparam int DEF_POOL_UNITS = 1024;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_MARK  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   typedef enum logic {
      MODE_ALLOC   = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef struct packed {
      logic              hit;
      logic [POS_W-1:0]  pos;
      logic [CALC_W-1:0] run;
   } row_eval_type;

endpackage
`default_nettype wire

### hw/rtl/ffua_row_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffua_row_eval
// Evaluates one map word during a first-fit scan: finds the lowest unit at
// which the free run reaches the requested length and the run carried out.
// ----------------------------------------------------------------------------
module ffua_row_eval (
   input  wire logic [ffua_pkg::WORD_W-1:0]   free_bits,
   input  wire logic [ffua_pkg::CALC_W-1:0]   run_in,
   input  wire logic [ffua_pkg::LENGTH_W-1:0] len,
   output ffua_pkg::row_eval_type             result
);

   logic [ffua_pkg::PP_W-1:0]   pp    [ffua_pkg::WORD_W];
   logic [ffua_pkg::CALC_W-1:0] run_j [ffua_pkg::WORD_W];
   logic [ffua_pkg::WORD_W-1:0] hit;

   // per unit: position just above the highest used unit at or below it
   always_comb begin
      for (int j = 0; j < ffua_pkg::WORD_W; j++) begin
         pp[j] = '0;
         for (int i = 0; i <= j; i++) begin
            if (!free_bits[i]) begin
               pp[j] = ffua_pkg::PP_W'(i + 1);
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < ffua_pkg::WORD_W; j++) begin
         if (pp[j] == '0) begin
            run_j[j] = run_in + ffua_pkg::CALC_W'(j + 1);
         end else begin
            run_j[j] = ffua_pkg::CALC_W'(j + 1) - ffua_pkg::CALC_W'(pp[j]);
         end
         hit[j] = (run_j[j] >= ffua_pkg::CALC_W'(len));
      end
   end

   always_comb begin
      result.hit = |hit;
      result.pos = '0;
      result.run = run_j[ffua_pkg::WORD_W-1];
      // lowest hitting unit wins
      for (int j = ffua_pkg::WORD_W - 1; j >= 0; j--) begin
         if (hit[j]) begin
            result.pos = ffua_pkg::POS_W'(j);
         end
      end
   end

endmodule
`default_nettype wire

### hw/rtl/first_fit_unit_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_top
// First-fit allocator over a pool of units with a word-wide occupancy map.
//
//   channel  dir  handshake              payload
//   req_     in   req_valid/req_ready    req_mode, req_length, req_offset
//   rsp_     out  rsp_valid/rsp_ready    rsp_ok, rsp_start_res
//
// after reset the map is cleared one word a cycle
// allocate: scans one 16-unit map word a cycle through the single read port,
//   then marks the taken run with a read-modify-write of each word it spans
// release: read-modify-write of each word the run touches
// trivial items (zero length, out of range) go straight to the response state
// req_ready is low while an item is in work; the result register holds until
//   taken, and the next item is accepted while it waits
// ----------------------------------------------------------------------------
module first_fit_unit_allocator_top #(
   parameter int POOL_UNITS = ffua_pkg::DEF_POOL_UNITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic                            req_mode,
   input  wire logic [ffua_pkg::LENGTH_W-1:0]   req_length,
   input  wire logic [ffua_pkg::OFFSET_W-1:0]   req_offset,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_ok,
   output      logic [ffua_pkg::OFFSET_W-1:0]   rsp_start_res
);

   localparam int WW     = ffua_pkg::WORD_W;
   localparam int CW     = ffua_pkg::CALC_W;
   localparam int ROWS   = (POOL_UNITS + WW - 1) / WW;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int UNIT_W = $clog2(POOL_UNITS);
   localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
   localparam logic [WW-1:0] LAST_MASK = (POOL_UNITS % WW == 0) ? {WW{1'b1}} :
                                         WW'((32'd1 << (POOL_UNITS % WW)) - 32'd1);

   // map storage
   logic [WW-1:0] mem [ROWS];

   ffua_pkg::state_type state_ff, state_in;
   logic [ROW_AW-1:0]   scan_addr_ff, scan_addr_in;
   logic                issue_done_ff, issue_done_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [ROW_AW-1:0]   rd_row_ff;
   logic [WW-1:0]       rd_data_ff;
   logic [CW-1:0]       run_ff, run_in;
   logic [ffua_pkg::LENGTH_W-1:0] len_ff, len_in;
   logic [UNIT_W-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic                set_ff, set_in;
   logic                res_ok_ff, res_ok_in;
   logic [ffua_pkg::OFFSET_W-1:0] res_start_ff, res_start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [ffua_pkg::OFFSET_W-1:0] rsp_start_ff, rsp_start_in;

   logic              rd_en;
   logic [ROW_AW-1:0] rd_addr;
   logic              wr_en;
   logic [ROW_AW-1:0] wr_addr;
   logic [WW-1:0]     wr_data;

   logic [WW-1:0]     free_bits;
   ffua_pkg::row_eval_type ev;
   logic [CW-1:0]     hit_unit, hit_start, rel_sum;
   logic [ROW_AW-1:0] lo_row, hi_row, start_row;
   logic [ffua_pkg::POS_W-1:0] lb, hb;
   logic [WW-1:0]     mark_mask;
   logic              req_acc;

   assign req_acc = req_valid && req_ready;

   // units past the pool end count as used
   assign free_bits = ~rd_data_ff & ((rd_row_ff == LAST_ROW) ? LAST_MASK : {WW{1'b1}});

   ffua_row_eval u_row_eval (
      .free_bits (free_bits),
      .run_in    (run_ff),
      .len       (len_ff),
      .result    (ev)
   );

   assign hit_unit  = (CW'(rd_row_ff) << ffua_pkg::WORD_SHIFT) | CW'(ev.pos);
   assign hit_start = hit_unit + CW'(1) - CW'(len_ff);
   assign start_row = ROW_AW'(hit_start >> ffua_pkg::WORD_SHIFT);
   assign rel_sum   = CW'(req_offset) + CW'(req_length);

   assign lo_row = ROW_AW'(CW'(lo_ff) >> ffua_pkg::WORD_SHIFT);
   assign hi_row = ROW_AW'(CW'(hi_ff) >> ffua_pkg::WORD_SHIFT);

   // run mask within the word being rewritten
   assign lb = (rd_row_ff == lo_row) ? ffua_pkg::POS_W'(lo_ff) : '0;
   assign hb = (rd_row_ff == hi_row) ? ffua_pkg::POS_W'(hi_ff) : {ffua_pkg::POS_W{1'b1}};
   assign mark_mask = ({WW{1'b1}} << lb) & ({WW{1'b1}} >> (ffua_pkg::POS_W'(WW - 1) - hb));

   always_comb begin
      state_in      = state_ff;
      scan_addr_in  = scan_addr_ff;
      issue_done_in = issue_done_ff;
      rd_vld_in     = 1'b0;
      run_in        = run_ff;
      len_in        = len_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      set_in        = set_ff;
      res_ok_in     = res_ok_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_start_in  = rsp_start_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = scan_addr_ff;
      wr_data       = '0;

      case (state_ff)
         ffua_pkg::ST_CLEAR: begin
            wr_en        = 1'b1;
            scan_addr_in = scan_addr_ff + ROW_AW'(1);
            if (scan_addr_ff == LAST_ROW) begin
               state_in = ffua_pkg::ST_IDLE;
            end
         end

         ffua_pkg::ST_IDLE: begin
            if (req_acc) begin
               len_in        = req_length;
               run_in        = '0;
               issue_done_in = 1'b0;
               res_ok_in     = 1'b0;
               res_start_in  = '0;
               state_in      = ffua_pkg::ST_RESP;
               if (req_mode == ffua_pkg::MODE_ALLOC) begin
                  if (req_length == '0) begin
                     res_ok_in = 1'b1;
                  end else if (CW'(req_length) <= CW'(POOL_UNITS)) begin
                     scan_addr_in = '0;
                     state_in     = ffua_pkg::ST_SCAN;
                  end
               end else if (rel_sum <= CW'(POOL_UNITS)) begin
                  res_ok_in = 1'b1;
                  if (req_length != '0) begin
                     lo_in        = UNIT_W'(req_offset);
                     hi_in        = UNIT_W'(rel_sum - CW'(1));
                     set_in       = 1'b0;
                     scan_addr_in = ROW_AW'(CW'(req_offset) >> ffua_pkg::WORD_SHIFT);
                     state_in     = ffua_pkg::ST_MARK;
                  end
               end
            end
         end

         ffua_pkg::ST_SCAN: begin
            if (!issue_done_ff) begin
               rd_en         = 1'b1;
               rd_vld_in     = 1'b1;
               scan_addr_in  = scan_addr_ff + ROW_AW'(1);
               issue_done_in = (scan_addr_ff == LAST_ROW);
            end
            if (rd_vld_ff) begin
               run_in = ev.run;
               if (ev.hit) begin
                  lo_in         = UNIT_W'(hit_start);
                  hi_in         = UNIT_W'(hit_unit);
                  set_in        = 1'b1;
                  res_ok_in     = 1'b1;
                  res_start_in  = ffua_pkg::OFFSET_W'(hit_start);
                  scan_addr_in  = start_row;
                  issue_done_in = 1'b0;
                  rd_vld_in     = 1'b0;
                  state_in      = ffua_pkg::ST_MARK;
               end else if (rd_row_ff == LAST_ROW) begin
                  rd_vld_in = 1'b0;
                  state_in  = ffua_pkg::ST_RESP;
               end
            end
         end

         ffua_pkg::ST_MARK: begin
            if (!issue_done_ff) begin
               rd_en         = 1'b1;
               rd_vld_in     = 1'b1;
               scan_addr_in  = scan_addr_ff + ROW_AW'(1);
               issue_done_in = (scan_addr_ff == hi_row);
            end
            if (rd_vld_ff) begin
               // read-modify-write one word behind the read
               wr_en   = 1'b1;
               wr_addr = rd_row_ff;
               wr_data = set_ff ? (rd_data_ff | mark_mask) : (rd_data_ff & ~mark_mask);
               if (rd_row_ff == hi_row) begin
                  rd_vld_in = 1'b0;
                  state_in  = ffua_pkg::ST_RESP;
               end
            end
         end

         ffua_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_start_in = res_start_ff;
               state_in     = ffua_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ffua_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_row_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffua_pkg::ST_CLEAR;
         scan_addr_ff  <= '0;
         issue_done_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_addr_ff  <= scan_addr_in;
         issue_done_ff <= issue_done_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff       <= run_in;
      len_ff       <= len_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      set_ff       <= set_in;
      res_ok_ff    <= res_ok_in;
      res_start_ff <= res_start_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign req_ready     = (state_ff == ffua_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_start_res = rsp_start_ff;

   a_rd_vld_in_work: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ffua_pkg::ST_SCAN || state_ff == ffua_pkg::ST_MARK))
      else $error("read data flagged outside scan or mark");

   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffua_pkg::ST_MARK) |-> (lo_ff <= hi_ff))
      else $error("mark run has start past end");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("ready again straight after an item");

   a_resp_loads: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ffua_pkg::ST_RESP && state_ff == ffua_pkg::ST_IDLE) |-> rsp_valid_ff)
      else $error("result not presented on leaving response state");

endmodule
`default_nettype wire
